// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted.
`define RE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset.
`define RE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RE_ASSERT(lbl, clk, rst_n, prop)
`define RE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/rotenc_pkg.sv =====
// Types and constants of the rotary encoder gesture decoder.
`default_nettype none
package rotenc_pkg;

    localparam int COUNTER_WIDTH_DEF = 8;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 10;
    localparam int LONG_W            = 8;
    localparam int WINDOW_W          = 8;
    localparam int DIV_W             = 10;

    localparam logic [LONG_W-1:0]   LONG_PRESS_RESET = 8'd10;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET     = 8'd15;
    localparam logic [DIV_W-1:0]    DIVIDER_RESET    = 10'd50;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_LEFT   = 3'd1,
        ACT_RIGHT  = 3'd2,
        ACT_CLICK  = 3'd3,
        ACT_DOUBLE = 3'd4,
        ACT_LONG   = 3'd5
    } gesture_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_WINDOW     = 2'd1,
        CFG_DIVIDER    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic clear_action;
        logic pin_switch;
        logic pin_b;
        logic pin_a;
    } item_t;

    typedef struct packed {
        logic [DIV_W-1:0]    switch_divider;
        logic [WINDOW_W-1:0] double_click_window;
        logic [LONG_W-1:0]   long_press_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/rotenc_decoder.sv =====
// Gesture state, the per-tick rotation update and the prescaled switch update.
`default_nettype none
`include "assert_macros.svh"
module rotenc_decoder
    import rotenc_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         step_en,
    input  item_t       item,
    input  cfg_t        cfg,
    output logic [2:0]  action_next,
    output logic        changed_next
);

    localparam int CW    = COUNTER_WIDTH;
    localparam int CMP_W = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_TWO = CW'(2);

    logic          armed_reg,  armed_next;
    logic          held_reg,   held_next;
    logic          long_seen_reg, long_seen_next;
    logic          pending_reg, pending_next;
    logic [CW-1:0] length_reg, length_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] timer_reg,  timer_next;
    gesture_t      action_reg, action_nv;
    logic [DIV_W-1:0] presc_reg, presc_next;

    logic [DIV_W:0]   presc_inc;
    logic [CMP_W-1:0] window_wide;
    logic             sw_step;
    logic             released;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_ONE;
    endfunction

    always_comb
    begin
        armed_next     = armed_reg;
        held_next      = held_reg;
        long_seen_next = long_seen_reg;
        pending_next   = pending_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        timer_next     = timer_reg;
        action_nv      = item.clear_action ? ACT_NONE : action_reg;
        changed_next   = 1'b0;
        released       = item.pin_switch;
        window_wide    = CMP_W'(cfg.double_click_window);

        // rotation: arm when exactly one pin is high, disarm when both are high
        if (!armed_reg)
        begin
            if (item.pin_a && !item.pin_b)
            begin
                action_nv    = ACT_LEFT;
                armed_next   = 1'b1;
                changed_next = 1'b1;
            end
            else if (!item.pin_a && item.pin_b)
            begin
                action_nv    = ACT_RIGHT;
                armed_next   = 1'b1;
                changed_next = 1'b1;
            end
        end
        else if (item.pin_a && item.pin_b)
        begin
            armed_next = 1'b0;
        end

        presc_inc = {1'b0, presc_reg} + (DIV_W+1)'(1);
        sw_step   = (presc_inc >= {1'b0, cfg.switch_divider});
        presc_next = sw_step ? '0 : presc_inc[DIV_W-1:0];

        if (sw_step)
        begin
            if (!held_reg)
            begin
                if (!released)
                begin
                    held_next   = 1'b1;
                    length_next = '0;
                    count_next  = sat_inc(count_reg);
                    if (count_next == CNT_ONE)
                    begin
                        timer_next   = window_wide[CW-1:0];
                        pending_next = 1'b1;
                    end
                end
            end
            else
            begin
                length_next = sat_inc(length_reg);
                if (released)
                begin
                    held_next = 1'b0;
                    if ((CMP_W'(length_next) >= CMP_W'(cfg.long_press_ticks)) && !pending_reg)
                    begin
                        action_nv      = ACT_LONG;
                        changed_next   = 1'b1;
                        long_seen_next = 1'b1;
                        count_next     = '0;
                    end
                    else if (!long_seen_reg && (count_reg >= CNT_TWO))
                    begin
                        action_nv    = ACT_DOUBLE;
                        changed_next = 1'b1;
                        count_next   = '0;
                    end
                    long_seen_next = 1'b0;
                    pending_next   = 1'b0;
                end
            end

            // double-click window
            if (timer_next != '0)
            begin
                timer_next = timer_next - CNT_ONE;
                if (timer_next == '0)
                begin
                    if (count_next == CNT_ONE)
                    begin
                        action_nv    = released ? ACT_CLICK : ACT_LONG;
                        changed_next = 1'b1;
                    end
                    count_next = '0;
                end
            end
        end

        action_next = action_nv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            held_reg      <= 1'b0;
            long_seen_reg <= 1'b0;
            pending_reg   <= 1'b0;
            length_reg    <= '0;
            count_reg     <= '0;
            timer_reg     <= '0;
            action_reg    <= ACT_NONE;
            presc_reg     <= '0;
        end
        else if (step_en)
        begin
            armed_reg     <= armed_next;
            held_reg      <= held_next;
            long_seen_reg <= long_seen_next;
            pending_reg   <= pending_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            timer_reg     <= timer_next;
            action_reg    <= action_nv;
            presc_reg     <= presc_next;
        end
    end

    `RE_ASSERT(a_hold_when_idle, clk, rst_n, !step_en |=> $stable(action_reg) && $stable(presc_reg))
    `RE_ASSERT(a_change_sets_action, clk, rst_n, step_en && changed_next |=> action_reg != ACT_NONE)
    `RE_ASSERT(a_keep_unless_written, clk, rst_n, step_en && !changed_next && !item.clear_action |=> action_reg == $past(action_reg))

endmodule
`default_nettype wire

// ===== rtl/rotary_encoder_gesture_decoder_core.sv =====
// Top level of the rotary encoder gesture decoder: stream ports, config registers, pipeline.
// Each tick passes the input register and then the output register, which drives m_tvalid.
// Throughput: one tick per cycle while m_tready is held high; an input register and
// an output register part the two sides, so the input register takes one tick while a result waits.
// Reset (rst_n low, asynchronous): both stages empty, all gesture state zero, action none,
// config back to long press 10, window 15, divider 50.
`default_nettype none
`include "assert_macros.svh"
module rotary_encoder_gesture_decoder_core
    import rotenc_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    // input ticks
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [7:0]            s_tdata,   // pin_a, pin_b, pin_switch, clear_action, 4'b0
    // results
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [7:0]            m_tdata,   // current_action[2:0], action_changed, 4'b0
    // configuration writes
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_INDEX_W-1:0] cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data
);

    item_t       in_reg;
    logic        in_valid_reg;
    logic [2:0]  act_out_reg;
    logic        chg_out_reg;
    logic        out_valid_reg;
    cfg_t        cfg_reg;

    logic        advance;
    logic [2:0]  action_next;
    logic        changed_next;

    // input stage advances when the output slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, chg_out_reg, act_out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= item_t'(s_tdata[3:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            act_out_reg <= action_next;
            chg_out_reg <= changed_next;
        end
    end

    // config registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks    <= LONG_PRESS_RESET;
            cfg_reg.double_click_window <= WINDOW_RESET;
            cfg_reg.switch_divider      <= DIVIDER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_LONG_PRESS: cfg_reg.long_press_ticks    <= cfg_data[LONG_W-1:0];
                CFG_WINDOW:     cfg_reg.double_click_window <= cfg_data[WINDOW_W-1:0];
                CFG_DIVIDER:    cfg_reg.switch_divider      <= cfg_data[DIV_W-1:0];
                default:        ;
            endcase
        end
    end

    rotenc_decoder #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .item         (in_reg),
        .cfg          (cfg_reg),
        .action_next  (action_next),
        .changed_next (changed_next)
    );

    `RE_ASSERT(a_stall_blocks_input, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
    `RE_ASSERT(a_advance_fills_output, clk, rst_n, advance |=> out_valid_reg)
    `RE_ASSERT(a_stage_holds, clk, rst_n, in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))

endmodule
`default_nettype wire
